// File: design/hs1_pkg.sv
// Constants and types shared by the HMAC-SHA1 engine.
package hs1_pkg;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5c5c5c5c;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          NUM_KEY = 8;

    typedef logic [31:0] t_word;

    // Round function and constant for round number
    function automatic t_word round_f(input logic [6:0] rnd, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic t_word round_k(input logic [6:0] rnd);
        t_word k;
        if (rnd < 7'd20) begin
            k = K0;
        end else if (rnd < 7'd40) begin
            k = K1;
        end else if (rnd < 7'd60) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction
endpackage

// File: design/hmac_sha1_engine_top.sv
// HMAC-SHA1 engine: byte-streamed message, one shared SHA-1 round unit.
// Each byte is placed in the block and control returns to idle; a byte that
// fills a block first runs a compression (80 rounds, add, dispatch). The first
// item of a message also compresses the key block. End of message runs up to
// four compressions, then five result transactions. o_stall is high until idle.
// Synchronous active-low reset clears control and the key registers.
module hmac_sha1_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KEY   = 4'd1;   // load key block
    localparam logic [3:0] S_COMP  = 4'd2;   // run rounds
    localparam logic [3:0] S_FIN   = 4'd3;   // add chain
    localparam logic [3:0] S_BYTE  = 4'd4;   // place a byte
    localparam logic [3:0] S_PADB  = 4'd5;   // padding bytes
    localparam logic [3:0] S_LEN   = 4'd6;   // length words
    localparam logic [3:0] S_OUTB  = 4'd7;   // outer data block
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;   // dispatch after compression

    localparam logic [1:0] P_MSG   = 2'd0;   // compression during message
    localparam logic [1:0] P_OKEY  = 2'd1;   // after inner final block
    localparam logic [1:0] P_ODAT  = 2'd2;   // after outer key block
    localparam logic [1:0] P_DONE  = 2'd3;   // after outer data block

    logic [63:0] r_key [hs1_pkg::NUM_KEY];
    logic [3:0]  r_state;
    logic [1:0]  r_phase;
    logic        r_open, r_last, r_pres, r_padding, r_pad_first;
    logic [7:0]  r_byte;
    logic [63:0] r_bitlen;
    logic [5:0]  r_fill;
    logic [6:0]  r_rnd;
    logic [2:0]  r_cnt;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_inner [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_pad;

    logic [31:0] n_t, n_wx;
    logic [3:0]  w_idx;
    logic [31:0] w_bytes;
    logic [7:0]  cur_byte;
    logic [4:0]  sh;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);
    assign o_digest_word = r_h[r_cnt];
    assign o_word_index = r_cnt;
    assign o_last_word = (r_cnt == 3'd4);

    // w[i] for i>=16 computed in place on a 16-entry circular schedule
    assign n_wx = r_w[4'(r_rnd[3:0] + 4'd13)] ^ r_w[4'(r_rnd[3:0] + 4'd8)]
                ^ r_w[4'(r_rnd[3:0] + 4'd2)] ^ r_w[r_rnd[3:0]];
    always_comb begin
        logic [31:0] wi;
        wi = (r_rnd < 7'd16) ? r_w[r_rnd[3:0]] : {n_wx[30:0], n_wx[31]};
        n_t = {r_a[26:0], r_a[31:27]} + hs1_pkg::round_f(r_rnd, r_b, r_c, r_d)
            + r_e + hs1_pkg::round_k(r_rnd) + wi;
    end

    assign w_idx = r_fill[5:2];
    assign cur_byte = r_padding ? (r_pad_first ? hs1_pkg::PAD_BYTE : 8'h00) : r_byte;
    assign sh = 5'(5'd24 - {r_fill[1:0], 3'b000});
    assign w_bytes = (r_fill[1:0] == 2'd0) ? (32'(cur_byte) << sh)
                   : (r_w[w_idx] | (32'(cur_byte) << sh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open <= 1'b0;
            r_bitlen <= '0;
            r_fill <= '0;
            r_cnt <= '0;
            for (int i = 0; i < hs1_pkg::NUM_KEY; i++) r_key[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key[i_cfg_index] <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_byte <= i_data_byte;
                        r_pres <= i_byte_present;
                        r_last <= i_end_of_message;
                        r_padding <= 1'b0;
                        if (!r_open) begin
                            r_pad <= hs1_pkg::IPAD;
                            r_phase <= P_MSG;
                            r_h[0] <= hs1_pkg::H0; r_h[1] <= hs1_pkg::H1;
                            r_h[2] <= hs1_pkg::H2; r_h[3] <= hs1_pkg::H3;
                            r_h[4] <= hs1_pkg::H4;
                            r_bitlen <= 64'd512;
                            r_fill <= '0;
                            r_open <= 1'b1;
                            r_state <= S_KEY;
                        end else begin
                            r_state <= S_BYTE;
                        end
                    end
                end
                S_KEY: begin
                    for (int i = 0; i < hs1_pkg::NUM_KEY; i++) begin
                        r_w[2*i]   <= r_key[i][63:32] ^ r_pad;
                        r_w[2*i+1] <= r_key[i][31:0] ^ r_pad;
                    end
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                    r_rnd <= '0;
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    if (r_rnd >= 7'd16) begin
                        r_w[r_rnd[3:0]] <= {n_wx[30:0], n_wx[31]};
                    end
                    r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a; r_a <= n_t;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    case (r_phase)
                        P_MSG: begin
                            // key block, full data block or padding block done
                            if (r_padding) r_state <= S_PADB;
                            else if (r_pres) r_state <= S_BYTE;
                            else if (r_last) begin
                                r_padding <= 1'b1;
                                r_pad_first <= 1'b1;
                                r_state <= S_PADB;
                            end else r_state <= S_IDLE;
                        end
                        P_OKEY: begin
                            // hold the inner digest while the outer key block runs
                            r_pad <= hs1_pkg::OPAD;
                            for (int i = 0; i < 5; i++) r_inner[i] <= r_h[i];
                            r_h[0] <= hs1_pkg::H0; r_h[1] <= hs1_pkg::H1;
                            r_h[2] <= hs1_pkg::H2; r_h[3] <= hs1_pkg::H3;
                            r_h[4] <= hs1_pkg::H4;
                            r_phase <= P_ODAT;
                            r_state <= S_KEY;
                        end
                        P_ODAT: r_state <= S_OUTB;
                        default: begin
                            r_cnt <= '0;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_BYTE: begin
                    if (r_pres) begin
                        r_w[w_idx] <= w_bytes;
                        r_bitlen <= r_bitlen + 64'd8;
                        r_pres <= 1'b0;
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                            r_d <= r_h[3]; r_e <= r_h[4];
                            r_rnd <= '0;
                            r_state <= S_COMP;
                        end else if (r_last) begin
                            r_padding <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_state <= S_PADB;
                        end else r_state <= S_IDLE;
                    end else if (r_last) begin
                        r_padding <= 1'b1;
                        r_pad_first <= 1'b1;
                        r_state <= S_PADB;
                    end else r_state <= S_IDLE;
                end
                S_PADB: begin
                    // place 0x80, then zero-fill until 56 bytes are in the block
                    if (!r_pad_first && r_fill == 6'd56) begin
                        r_state <= S_LEN;
                    end else begin
                        r_w[w_idx] <= w_bytes;
                        r_pad_first <= 1'b0;
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                            r_d <= r_h[3]; r_e <= r_h[4];
                            r_rnd <= '0;
                            r_state <= S_COMP;
                        end
                    end
                end
                S_LEN: begin
                    r_w[14] <= r_bitlen[63:32];
                    r_w[15] <= r_bitlen[31:0];
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                    r_rnd <= '0;
                    r_fill <= '0;
                    r_phase <= P_OKEY;
                    r_state <= S_COMP;
                end
                S_OUTB: begin
                    for (int i = 0; i < 5; i++) r_w[i] <= r_inner[i];
                    r_w[5] <= 32'h80000000;
                    for (int i = 6; i < 15; i++) r_w[i] <= '0;
                    r_w[15] <= 32'd672;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                    r_rnd <= '0;
                    r_phase <= P_DONE;
                    r_state <= S_COMP;
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        if (r_cnt == 3'd4) begin
                            r_cnt <= '0;
                            r_open <= 1'b0;
                            r_bitlen <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word_index <= 3'd4)) else $error("word index out of range");
    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_rnd <= 7'd79)) else $error("round overrun");
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word && !i_stall) |=> !r_open) else $error("message not closed");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_fill == 6'd56)) else $error("bad pad fill");
`endif
endmodule
